// ----- design/sik_pkg.sv -----
// ----------------------------------------------------------------------------
// sik_pkg
// Shared types, widths, reset values and the CORDIC arctangent table for the
// swerve inverse kinematics core.
// ----------------------------------------------------------------------------
package sik_pkg;

  localparam int CMD_W            = 16;
  localparam int VEC_W            = 19;  // wheel vector component, signed
  localparam int SQR_W            = 34;  // one square
  localparam int RAD_W            = 35;  // sum of two squares
  localparam int SQW              = 36;  // square root working width
  localparam int MAG_W            = 18;  // magnitude, also sqrt steps
  localparam int DIV_STEPS        = 16;  // quotient bits of normalization
  localparam int NUM_W            = 34;  // normalization dividend
  localparam int CW               = 35;  // CORDIC x/y width
  localparam int CORDIC_MAX       = 24;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int FIFO_DEPTH       = 4;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 16;
  localparam int LANES            = 4;

  localparam logic [15:0] LENGTH_RST = 16'd23170;
  localparam logic [15:0] WIDTH_RST  = 16'd23170;
  localparam logic [14:0] MOVE_RST   = 15'd4915;
  localparam logic [14:0] TURN_RST   = 15'd328;
  localparam logic [17:0] FULL_SPEED = 18'd32768;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] TURN_ATAN [CORDIC_MAX] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LENGTH  = 2'd0,
    CFG_WIDTH   = 2'd1,
    CFG_MOVE_DB = 2'd2,
    CFG_TURN_DB = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] length_ratio;
    logic [15:0] width_ratio;
    logic [14:0] move_deadband;
    logic [14:0] turn_deadband;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] forward_cmd;
    logic signed [15:0] strafe_cmd;
    logic signed [15:0] rotate_cmd;
  } cmd_t;

  typedef struct packed {
    logic        hold_steer;
    logic [15:0] speed_front_left;
    logic [15:0] speed_front_right;
    logic [15:0] speed_rear_left;
    logic [15:0] speed_rear_right;
    logic [15:0] steer_front_left;
    logic [15:0] steer_front_right;
    logic [15:0] steer_rear_left;
    logic [15:0] steer_rear_right;
  } res_t;

  // classified word handed from front to back
  typedef struct packed {
    logic                    hold;
    logic signed [VEC_W-1:0] a;
    logic signed [VEC_W-1:0] b;
    logic signed [VEC_W-1:0] c;
    logic signed [VEC_W-1:0] d;
  } vec_t;

endpackage

// ----- design/sik_stream_if.sv -----
// ----------------------------------------------------------------------------
// sik_stream_if
// Valid/ready stream channel carrying one payload word.
// ----------------------------------------------------------------------------
interface sik_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/sik_front.sv -----
// ----------------------------------------------------------------------------
// sik_front
// Accepts commands, applies the deadbands, scales rotation by the length
// and width ratios and forms the four wheel vector components.
// ----------------------------------------------------------------------------
module sik_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  sik_pkg::cmd_t       in_data,
  output logic                in_ready,
  input  sik_pkg::cfg_t       cfg,
  output logic                push,
  output sik_pkg::vec_t       push_data,
  input  logic                full
);

  function automatic logic [16:0] abs17(logic signed [15:0] v);
    logic signed [16:0] e;
    e = 17'(v);
    abs17 = v[15] ? 17'(-e) : 17'(e);
  endfunction

  logic [16:0]        abs_f, abs_s, abs_t;
  logic               f_small, s_small, t_small, stop;
  logic signed [15:0] t_eff;
  logic signed [32:0] pl_nxt, pw_nxt;
  logic               fen;

  logic               f1_vld_r;
  logic               f1_hold_r;
  logic signed [15:0] f1_f_r, f1_s_r;
  logic signed [32:0] f1_pl_r, f1_pw_r;

  logic signed [33:0]                  rl, rw;
  logic signed [sik_pkg::VEC_W-1:0]    tl, tw, fe, se;

  assign abs_f   = abs17(in_data.forward_cmd);
  assign abs_s   = abs17(in_data.strafe_cmd);
  assign abs_t   = abs17(in_data.rotate_cmd);
  assign f_small = abs_f < {2'b00, cfg.move_deadband};
  assign s_small = abs_s < {2'b00, cfg.move_deadband};
  assign t_small = abs_t < {2'b00, cfg.turn_deadband};
  assign stop    = f_small && s_small && t_small;
  assign t_eff   = t_small ? 16'sd0 : in_data.rotate_cmd;
  assign pl_nxt  = t_eff * $signed({1'b0, cfg.length_ratio});
  assign pw_nxt  = t_eff * $signed({1'b0, cfg.width_ratio});

  assign fen      = !f1_vld_r || !full;
  assign in_ready = fen;
  assign push     = f1_vld_r && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
    end else if (fen) begin
      f1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fen) begin
      f1_hold_r <= stop;
      f1_f_r    <= in_data.forward_cmd;
      f1_s_r    <= in_data.strafe_cmd;
      f1_pl_r   <= pl_nxt;
      f1_pw_r   <= pw_nxt;
    end
  end

  // round half up to Q1.15
  assign rl = 34'(f1_pl_r) + 34'sd16384;
  assign rw = 34'(f1_pw_r) + 34'sd16384;
  assign tl = sik_pkg::VEC_W'(rl >>> 15);
  assign tw = sik_pkg::VEC_W'(rw >>> 15);
  assign fe = sik_pkg::VEC_W'(f1_f_r);
  assign se = sik_pkg::VEC_W'(f1_s_r);

  always_comb begin
    push_data.hold = f1_hold_r;
    push_data.a    = se - tl;
    push_data.b    = se + tl;
    push_data.c    = fe - tw;
    push_data.d    = fe + tw;
  end

endmodule

// ----- design/sik_queue.sv -----
// ----------------------------------------------------------------------------
// sik_queue
// Short FIFO between the classifying front and the arithmetic back.
// ----------------------------------------------------------------------------
module sik_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sik_pkg::vec_t wdata,
  output logic          full,
  input  logic          pop,
  output sik_pkg::vec_t rdata,
  output logic          empty
);

  localparam int DEPTH = sik_pkg::FIFO_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  sik_pkg::vec_t  mem [DEPTH];
  logic [AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [AW:0]    cnt_r;

  assign full  = cnt_r == (AW+1)'(DEPTH);
  assign empty = cnt_r == '0;
  assign rdata = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue read while empty");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count lost a word");
`endif

endmodule

// ----- design/sik_back.sv -----
// ----------------------------------------------------------------------------
// sik_back
// Arithmetic pipeline: squares, bit-serial square roots, speed
// normalization divide and CORDIC angle lanes, all under one stall enable.
// ----------------------------------------------------------------------------
module sik_back #(
  parameter int CORDIC_STEPS = sik_pkg::CORDIC_STEPS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  sik_pkg::vec_t q_data,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output sik_pkg::res_t out_data
);

  localparam int N      = CORDIC_STEPS;
  localparam int SQ     = sik_pkg::MAG_W;
  localparam int DV     = sik_pkg::DIV_STEPS;
  localparam int L      = sik_pkg::LANES;
  localparam int CW     = sik_pkg::CW;
  localparam int SQW    = sik_pkg::SQW;
  localparam int P_SQR  = 1;
  localparam int P_SUM  = 2;
  localparam int P_MAX  = P_SUM + SQ + 1;
  localparam int P_NUM  = P_MAX + 1;
  localparam int P_DEND = P_NUM + DV;
  localparam int P_OUT  = P_DEND + 1;
  localparam int P_ANG  = P_SQR + N + 1;
  // lanes: front left (a,c), front right (b,d), rear left (b,c), rear right (a,d)
  localparam int YSEL [L] = '{0, 1, 1, 0};
  localparam int XSEL [L] = '{2, 3, 2, 3};

  logic en;
  logic vld_r  [0:P_OUT];
  logic hold_r [0:P_OUT];

  assign en        = !vld_r[P_OUT] || out_ready;
  assign pop       = en && !q_empty;
  assign out_valid = vld_r[P_OUT];

  sik_pkg::vec_t v0_r;
  logic signed [sik_pkg::VEC_W-1:0] vc [L];

  always_comb begin
    vc[0] = v0_r.a;
    vc[1] = v0_r.b;
    vc[2] = v0_r.c;
    vc[3] = v0_r.d;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v0_r      <= q_data;
      hold_r[0] <= q_data.hold;
    end
  end

  for (genvar k = 1; k <= P_OUT; k++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        hold_r[k] <= hold_r[k-1];
      end
    end
  end

  // ---------------- magnitude: squares, sum, square root ----------------
  logic [sik_pkg::SQR_W-1:0] sq_r [L];
  logic [SQW-1:0]            sn_r [0:SQ][L];
  logic [SQW-1:0]            sr_r [0:SQ][L];

  for (genvar l = 0; l < L; l++) begin : g_sq
    logic signed [2*sik_pkg::VEC_W-1:0] sq_nxt;
    assign sq_nxt = vc[l] * vc[l];
    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[l]    <= sq_nxt[sik_pkg::SQR_W-1:0];
        sn_r[0][l] <= SQW'(sq_r[YSEL[l]]) + SQW'(sq_r[XSEL[l]]);
        sr_r[0][l] <= '0;
      end
    end
  end

  for (genvar k = 1; k <= SQ; k++) begin : g_sqrt
    localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (SQ - k));
    for (genvar l = 0; l < L; l++) begin : g_lane
      logic [SQW-1:0] trial;
      logic           ge;
      assign trial = sr_r[k-1][l] + BIT;
      assign ge    = sn_r[k-1][l] >= trial;
      always_ff @(posedge clk) begin
        if (en) begin
          sn_r[k][l] <= ge ? sn_r[k-1][l] - trial : sn_r[k-1][l];
          sr_r[k][l] <= ge ? (sr_r[k-1][l] >> 1) + BIT : sr_r[k-1][l] >> 1;
        end
      end
    end
  end

  // ---------------- largest speed and normalization ----------------
  logic [SQ-1:0] mag [L];
  logic [SQ-1:0] m01, m23, mx_nxt;
  logic [SQ-1:0] sp_r [L];
  logic [SQ-1:0] mx_r;
  logic          nrm_r;

  for (genvar l = 0; l < L; l++) begin : g_mag
    assign mag[l] = sr_r[SQ][l][SQ-1:0];
  end

  assign m01    = (mag[0] > mag[1]) ? mag[0] : mag[1];
  assign m23    = (mag[2] > mag[3]) ? mag[2] : mag[3];
  assign mx_nxt = (m01 > m23) ? m01 : m23;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < L; l++) begin
        sp_r[l] <= mag[l];
      end
      mx_r  <= mx_nxt;
      nrm_r <= mx_nxt > sik_pkg::FULL_SPEED;
    end
  end

  localparam int NW = sik_pkg::NUM_W;
  logic [NW-1:0] dr_r [0:DV][L];
  logic [15:0]   dq_r [0:DV][L];
  logic [SQ-1:0] ds_r [0:DV][L];
  logic [SQ-1:0] dm_r [0:DV];
  logic          dn_r [0:DV];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < L; l++) begin
        dr_r[0][l] <= NW'({sp_r[l], 15'd0}) + NW'(mx_r >> 1);
        dq_r[0][l] <= '0;
        ds_r[0][l] <= sp_r[l];
      end
      dm_r[0] <= mx_r;
      dn_r[0] <= nrm_r;
    end
  end

  for (genvar k = 1; k <= DV; k++) begin : g_div
    for (genvar l = 0; l < L; l++) begin : g_lane
      logic [NW-1:0] dsr;
      logic          ge;
      assign dsr = NW'(dm_r[k-1]) << (DV - k);
      assign ge  = dr_r[k-1][l] >= dsr;
      always_ff @(posedge clk) begin
        if (en) begin
          dr_r[k][l] <= ge ? dr_r[k-1][l] - dsr : dr_r[k-1][l];
          dq_r[k][l] <= dq_r[k-1][l] | (16'(ge) << (DV - k));
          ds_r[k][l] <= ds_r[k-1][l];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dm_r[k] <= dm_r[k-1];
        dn_r[k] <= dn_r[k-1];
      end
    end
  end

  // ---------------- CORDIC angle lanes ----------------
  logic signed [CW-1:0] cx_r [0:N][L];
  logic signed [CW-1:0] cy_r [0:N][L];
  logic [31:0]          cz_r [0:N][L];
  logic                 cf_r [0:N][L];   // zero vector
  logic [15:0]          ag_r [P_ANG:P_DEND][L];

  for (genvar l = 0; l < L; l++) begin : g_cprep
    logic signed [CW-1:0] xe, ye;
    assign xe = CW'(vc[XSEL[l]]) <<< 14;
    assign ye = CW'(vc[YSEL[l]]) <<< 14;
    always_ff @(posedge clk) begin
      if (en) begin
        cf_r[0][l] <= (xe == '0) && (ye == '0);
        cx_r[0][l] <= xe[CW-1] ? -xe : xe;
        cy_r[0][l] <= xe[CW-1] ? -ye : ye;
        cz_r[0][l] <= xe[CW-1] ? 32'h80000000 : 32'h0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cordic
    for (genvar l = 0; l < L; l++) begin : g_lane
      logic up;
      assign up = cy_r[i][l] > 0;
      always_ff @(posedge clk) begin
        if (en) begin
          cf_r[i+1][l] <= cf_r[i][l];
          if (up) begin
            cx_r[i+1][l] <= cx_r[i][l] + (cy_r[i][l] >>> i);
            cy_r[i+1][l] <= cy_r[i][l] - (cx_r[i][l] >>> i);
            cz_r[i+1][l] <= cz_r[i][l] + sik_pkg::TURN_ATAN[i];
          end else begin
            cx_r[i+1][l] <= cx_r[i][l] - (cy_r[i][l] >>> i);
            cy_r[i+1][l] <= cy_r[i][l] + (cx_r[i][l] >>> i);
            cz_r[i+1][l] <= cz_r[i][l] - sik_pkg::TURN_ATAN[i];
          end
        end
      end
    end
  end

  for (genvar l = 0; l < L; l++) begin : g_ang
    logic [31:0] zr;
    assign zr = cz_r[N][l] + 32'h00008000;
    always_ff @(posedge clk) begin
      if (en) begin
        ag_r[P_ANG][l] <= cf_r[N][l] ? 16'd0 : zr[31:16];
      end
    end
    for (genvar k = P_ANG + 1; k <= P_DEND; k++) begin : g_dly
      always_ff @(posedge clk) begin
        if (en) begin
          ag_r[k][l] <= ag_r[k-1][l];
        end
      end
    end
  end

  // ---------------- output register ----------------
  sik_pkg::res_t out_r;
  logic          out_nrm_r;
  logic [15:0]   spd [L];
  logic [15:0]   ang [L];

  always_comb begin
    for (int l = 0; l < L; l++) begin
      spd[l] = hold_r[P_DEND] ? 16'd0 :
               dn_r[DV] ? dq_r[DV][l] : ds_r[DV][l][15:0];
      ang[l] = hold_r[P_DEND] ? 16'd0 : ag_r[P_DEND][l];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.hold_steer        <= hold_r[P_DEND];
      out_r.speed_front_left  <= spd[0];
      out_r.speed_front_right <= spd[1];
      out_r.speed_rear_left   <= spd[2];
      out_r.speed_rear_right  <= spd[3];
      out_r.steer_front_left  <= ang[0];
      out_r.steer_front_right <= ang[1];
      out_r.steer_rear_left   <= ang[2];
      out_r.steer_rear_right  <= ang[3];
      out_nrm_r               <= dn_r[DV] && !hold_r[P_DEND];
    end
  end

  assign out_data = out_r;

`ifndef SYNTHESIS
  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_r.hold_steer) |->
      (out_r.speed_front_left == 16'd0) && (out_r.speed_front_right == 16'd0) &&
      (out_r.speed_rear_left == 16'd0) && (out_r.speed_rear_right == 16'd0) &&
      (out_r.steer_front_left == 16'd0) && (out_r.steer_rear_right == 16'd0))
    else $error("stop word carries drive values");
  a_speed_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_r.speed_front_left <= 16'd32768) && (out_r.speed_front_right <= 16'd32768) &&
      (out_r.speed_rear_left <= 16'd32768) && (out_r.speed_rear_right <= 16'd32768))
    else $error("wheel speed above full scale");
  a_norm_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_nrm_r) |->
      (out_r.speed_front_left == 16'd32768) || (out_r.speed_front_right == 16'd32768) ||
      (out_r.speed_rear_left == 16'd32768) || (out_r.speed_rear_right == 16'd32768))
    else $error("normalized word has no wheel at full speed");
`endif

endmodule

// ----- design/swerve_inverse_kinematics_core.sv -----
// ----------------------------------------------------------------------------
// swerve_inverse_kinematics_core
// Joystick command to four swerve wheel speeds and steering angles.
// ----------------------------------------------------------------------------
// One command word is taken per clock and one result word leaves per clock
// in steady flow. A command passes one front stage (deadbands,
// ratio multiply), the four-word queue, then the back pipeline of squares,
// 18 square-root steps, a max stage, 16 divide steps for speed
// normalization and the output register; the CORDIC_STEPS angle stages run
// alongside. The back pipeline holds as a whole while the output word is
// not taken; the queue then absorbs the front until it fills.
module swerve_inverse_kinematics_core #(
  parameter int CORDIC_STEPS = sik_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  sik_stream_if.sink                         in_cmd,
  sik_stream_if.source                       out_res,
  input  logic                               cfg_we,
  input  logic [sik_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sik_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  sik_pkg::cfg_t cfg_r;
  sik_pkg::vec_t push_data, q_data;
  sik_pkg::res_t res;
  sik_pkg::cmd_t cmd;
  logic          push, full, pop, q_empty, in_rdy, o_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.length_ratio  <= sik_pkg::LENGTH_RST;
      cfg_r.width_ratio   <= sik_pkg::WIDTH_RST;
      cfg_r.move_deadband <= sik_pkg::MOVE_RST;
      cfg_r.turn_deadband <= sik_pkg::TURN_RST;
    end else if (cfg_we) begin
      unique case (sik_pkg::cfg_idx_t'(cfg_index))
        sik_pkg::CFG_LENGTH:  cfg_r.length_ratio  <= cfg_wdata;
        sik_pkg::CFG_WIDTH:   cfg_r.width_ratio   <= cfg_wdata;
        sik_pkg::CFG_MOVE_DB: cfg_r.move_deadband <= cfg_wdata[14:0];
        sik_pkg::CFG_TURN_DB: cfg_r.turn_deadband <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  assign cmd          = in_cmd.data;
  assign in_cmd.ready = in_rdy;

  sik_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_cmd.valid),
    .in_data   (cmd),
    .in_ready  (in_rdy),
    .cfg       (cfg_r),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  sik_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (push_data),
    .full  (full),
    .pop   (pop),
    .rdata (q_data),
    .empty (q_empty)
  );

  sik_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (o_vld),
    .out_ready (out_res.ready),
    .out_data  (res)
  );

  assign out_res.valid = o_vld;
  assign out_res.data  = res;

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// Swerve inverse kinematics core testbench
// Drives joystick words with random gaps, predicts each result from its own
// model of the deadbands, wheel vectors, magnitudes, normalization and the
// CORDIC angles, and checks every result word field by field in order.
// ----------------------------------------------------------------------------
module testbench;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [sik_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [sik_pkg::CFG_DATA_W-1:0] cfg_wdata;

  sik_stream_if #(.T(sik_pkg::cmd_t)) cmd_ch ();
  sik_stream_if #(.T(sik_pkg::res_t)) res_ch ();

  swerve_inverse_kinematics_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_cmd   (cmd_ch.sink),
    .out_res  (res_ch.source),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  localparam int LATENCY = 60;
  localparam longint CYCLE_LIMIT = 400000;

  // predictor copy of the registers
  logic [15:0] len_ratio;
  logic [15:0] wid_ratio;
  logic [14:0] move_db;
  logic [14:0] turn_db;

  sik_pkg::res_t pending_res[$];
  int     n_errors;
  int     n_words;
  int     n_stops;
  longint cycle_cnt = 0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic longint floor_shift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint int_sqrt(longint n);
    longint res, bitv;
    res = 0;
    bitv = 64'sd1 <<< 62;
    while (bitv > n) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >>> 1) + bitv;
      end else begin
        res = res >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] steer_angle(longint y, longint x);
    logic [31:0] z;
    longint nx, ny;
    logic [31:0] zr;
    z = 0;
    if (x == 0 && y == 0) return 16'd0;
    x = x * 16384;
    y = y * 16384;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h80000000;
    end
    for (int i = 0; i < sik_pkg::CORDIC_STEPS_DEF && i < sik_pkg::CORDIC_MAX; i++) begin
      if (y > 0) begin
        nx = x + floor_shift(y, i);
        ny = y - floor_shift(x, i);
        z = z + sik_pkg::TURN_ATAN[i];
      end else begin
        nx = x - floor_shift(y, i);
        ny = y + floor_shift(x, i);
        z = z - sik_pkg::TURN_ATAN[i];
      end
      x = nx;
      y = ny;
    end
    zr = z + 32'h8000;
    return zr[31:16];
  endfunction

  function automatic sik_pkg::res_t predict_wheels(sik_pkg::cmd_t cmd);
    sik_pkg::res_t r;
    longint f, s, t, tl, tw, a, b, c, d, m;
    longint sp[4];
    f = cmd.forward_cmd;
    s = cmd.strafe_cmd;
    t = cmd.rotate_cmd;
    r = '0;
    if ((t < 0 ? -t : t) < turn_db) t = 0;
    if ((f < 0 ? -f : f) < move_db && (s < 0 ? -s : s) < move_db
        && (t < 0 ? -t : t) < turn_db) begin
      r.hold_steer = 1'b1;
      return r;
    end
    tl = floor_shift(t * len_ratio + 16384, 15);
    tw = floor_shift(t * wid_ratio + 16384, 15);
    a = s - tl;
    b = s + tl;
    c = f - tw;
    d = f + tw;
    sp[0] = int_sqrt(a * a + c * c);
    sp[1] = int_sqrt(b * b + d * d);
    sp[2] = int_sqrt(b * b + c * c);
    sp[3] = int_sqrt(a * a + d * d);
    m = sp[0];
    for (int k = 1; k < 4; k++) if (sp[k] > m) m = sp[k];
    if (m > 32768) begin
      for (int k = 0; k < 4; k++) sp[k] = (sp[k] * 32768 + m / 2) / m;
    end
    r.speed_front_left  = sp[0][15:0];
    r.speed_front_right = sp[1][15:0];
    r.speed_rear_left   = sp[2][15:0];
    r.speed_rear_right  = sp[3][15:0];
    r.steer_front_left  = steer_angle(a, c);
    r.steer_front_right = steer_angle(b, d);
    r.steer_rear_left   = steer_angle(b, c);
    r.steer_rear_right  = steer_angle(a, d);
    return r;
  endfunction

  // result side: random stall per word, checks against the oldest prediction
  initial begin
    int stall;
    sik_pkg::res_t exp_r;
    sik_pkg::res_t got;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      repeat (stall) @(negedge clk);
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
      got = res_ch.data;
      if (pending_res.size() == 0) begin
        $error("result word with nothing expected");
        n_errors++;
      end else begin
        exp_r = pending_res.pop_front();
        if (exp_r.hold_steer) n_stops++;
        if (got.hold_steer !== exp_r.hold_steer) begin
          $error("hold_steer exp %0d got %0d", exp_r.hold_steer, got.hold_steer); n_errors++;
        end
        if (got.speed_front_left !== exp_r.speed_front_left) begin
          $error("speed_front_left exp %0d got %0d", exp_r.speed_front_left,
                 got.speed_front_left); n_errors++;
        end
        if (got.speed_front_right !== exp_r.speed_front_right) begin
          $error("speed_front_right exp %0d got %0d", exp_r.speed_front_right,
                 got.speed_front_right); n_errors++;
        end
        if (got.speed_rear_left !== exp_r.speed_rear_left) begin
          $error("speed_rear_left exp %0d got %0d", exp_r.speed_rear_left,
                 got.speed_rear_left); n_errors++;
        end
        if (got.speed_rear_right !== exp_r.speed_rear_right) begin
          $error("speed_rear_right exp %0d got %0d", exp_r.speed_rear_right,
                 got.speed_rear_right); n_errors++;
        end
        if (got.steer_front_left !== exp_r.steer_front_left) begin
          $error("steer_front_left exp %0d got %0d", exp_r.steer_front_left,
                 got.steer_front_left); n_errors++;
        end
        if (got.steer_front_right !== exp_r.steer_front_right) begin
          $error("steer_front_right exp %0d got %0d", exp_r.steer_front_right,
                 got.steer_front_right); n_errors++;
        end
        if (got.steer_rear_left !== exp_r.steer_rear_left) begin
          $error("steer_rear_left exp %0d got %0d", exp_r.steer_rear_left,
                 got.steer_rear_left); n_errors++;
        end
        if (got.steer_rear_right !== exp_r.steer_rear_right) begin
          $error("steer_rear_right exp %0d got %0d", exp_r.steer_rear_right,
                 got.steer_rear_right); n_errors++;
        end
      end
      @(negedge clk);
      res_ch.ready <= 1'b0;
    end
  end

  // valid stays up between back-to-back words; drain_results drops it
  task automatic send_cmd(logic [15:0] fwd, logic [15:0] str, logic [15:0] rot);
    int gap;
    sik_pkg::cmd_t cmd;
    cmd.forward_cmd = fwd;
    cmd.strafe_cmd  = str;
    cmd.rotate_cmd  = rot;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.data  <= cmd;
    cmd_ch.valid <= 1'b1;
    do @(posedge clk); while (!cmd_ch.ready);
    pending_res.push_back(predict_wheels(cmd));
    n_words++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    while (pending_res.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  // only while idle
  task automatic write_reg(sik_pkg::cfg_idx_t idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      sik_pkg::CFG_LENGTH:  len_ratio = val;
      sik_pkg::CFG_WIDTH:   wid_ratio = val;
      sik_pkg::CFG_MOVE_DB: move_db   = val[14:0];
      sik_pkg::CFG_TURN_DB: turn_db   = val[14:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic test_directed();
    logic [15:0] vals[6] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'd4915, 16'hECCD};
    send_cmd(16'h0000, 16'h0000, 16'h0000);   // stop
    send_cmd(16'h0000, 16'h0000, 16'd327);    // rotate just in deadband
    send_cmd(16'h0000, 16'h0000, 16'd328);
    send_cmd(16'h8000, 16'h8000, 16'h8000);   // most negative everywhere
    send_cmd(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_cmd(16'h8000, 16'h0000, 16'h0000);
    send_cmd(16'h0000, 16'h7FFF, 16'h0000);
    for (int i = 0; i < 6; i++) send_cmd(vals[i], vals[5 - i], vals[(i + 2) % 6]);
    send_cmd(16'h0000, 16'h0000, 16'h7FFF);   // pure rotation
    send_cmd(16'd4914, 16'hECCE, 16'h0000);   // just inside move deadband
    drain_results();
  endtask

  task automatic test_random(int count);
    logic [15:0] f, s, t;
    for (int i = 0; i < count; i++) begin
      f = 16'($urandom);
      s = 16'($urandom);
      t = 16'($urandom);
      case ($urandom_range(0, 5))
        0: begin f = 16'($urandom_range(0, 9000) - 4500);
                 s = 16'($urandom_range(0, 9000) - 4500);
                 t = 16'($urandom_range(0, 700) - 350); end
        1: t = 16'($urandom_range(0, 2000) - 1000);
        2: begin f = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF; end
        default: ;
      endcase
      send_cmd(f, s, t);
    end
    drain_results();
  endtask

  task automatic test_settings();
    write_reg(sik_pkg::CFG_LENGTH, 16'd32768);
    write_reg(sik_pkg::CFG_WIDTH, 16'd0);
    write_reg(sik_pkg::CFG_MOVE_DB, 16'd0);
    write_reg(sik_pkg::CFG_TURN_DB, 16'd0);
    test_random(300);
    write_reg(sik_pkg::CFG_LENGTH, 16'd0);
    write_reg(sik_pkg::CFG_WIDTH, 16'd32768);
    write_reg(sik_pkg::CFG_MOVE_DB, 16'd32767);
    write_reg(sik_pkg::CFG_TURN_DB, 16'd32767);
    test_random(300);
    write_reg(sik_pkg::CFG_LENGTH, 16'($urandom_range(0, 32768)));
    write_reg(sik_pkg::CFG_WIDTH, 16'($urandom_range(0, 32768)));
    write_reg(sik_pkg::CFG_MOVE_DB, 16'($urandom_range(0, 12000)));
    write_reg(sik_pkg::CFG_TURN_DB, 16'($urandom_range(0, 3000)));
    test_random(400);
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.data  = '0;
    n_errors     = 0;
    n_words      = 0;
    n_stops      = 0;
    len_ratio    = sik_pkg::LENGTH_RST;
    wid_ratio    = sik_pkg::WIDTH_RST;
    move_db      = sik_pkg::MOVE_RST;
    turn_db      = sik_pkg::TURN_RST;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    repeat (2) @(negedge clk);
    test_directed();
    test_random(900);
    test_settings();
    $display("covered %0d commands, %0d stop results, over four register settings",
             n_words, n_stops);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
